@@ src/utrd_pkg.sv @@
// ----------------------------------------------------------------------------
// utrd_pkg
// Shared widths, constants and helper functions for the radix digit converter.
// ----------------------------------------------------------------------------
package utrd_pkg;

    localparam int VALUE_W       = 64;  // width of the value field on the port
    localparam int RADIX_W       = 6;
    localparam int CHAR_W        = 7;
    localparam int BITS_PER_STEP = 4;   // quotient bits resolved per divide cycle
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [RADIX_W-1:0] RADIX_MIN     = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX     = 6'd36;
    localparam logic [RADIX_W-1:0] DECIMAL_LIMIT = 6'd10;
    localparam logic [CHAR_W-1:0]  DIGIT_BASE    = 7'd48;
    localparam logic [CHAR_W-1:0]  LETTER_BASE   = 7'd55;

    // Force the base into the supported range.
    function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] res;
        res = r;
        if (r < RADIX_MIN) begin
            res = RADIX_MIN;
        end else if (r > RADIX_MAX) begin
            res = RADIX_MAX;
        end
        return res;
    endfunction

    // Map a digit value to its ASCII code: '0'..'9', then 'A' onward.
    function automatic logic [CHAR_W-1:0] digit_to_char(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] res;
        if (d < DECIMAL_LIMIT) begin
            res = DIGIT_BASE + {1'b0, d};
        end else begin
            res = LETTER_BASE + {1'b0, d};
        end
        return res;
    endfunction

endpackage

@@ src/utrd_if.sv @@
// ----------------------------------------------------------------------------
// utrd_in_if / utrd_out_if
// Valid/ready channels for the value input and the digit output.
// ----------------------------------------------------------------------------
interface utrd_in_if;
    logic                          valid;
    logic                          ready;
    logic [utrd_pkg::VALUE_W-1:0]  value;
    logic [utrd_pkg::RADIX_W-1:0]  radix;

    modport source (output valid, output value, output radix, input ready);
    modport sink   (input valid, input value, input radix, output ready);
endinterface

interface utrd_out_if;
    logic                         valid;
    logic                         ready;
    logic [utrd_pkg::CHAR_W-1:0]  digit_char;
    logic                         last;

    modport source (output valid, output digit_char, output last, input ready);
    modport sink   (input valid, input digit_char, input last, output ready);
endinterface

@@ src/unsigned_to_radix_digits_top.sv @@
// ----------------------------------------------------------------------------
// unsigned_to_radix_digits_top
// Converts an unsigned value to ASCII digits in radix 2..36, MSB digit first.
// ----------------------------------------------------------------------------
//
//   channel | dir | handshake     | payload
//   --------+-----+---------------+-----------------------------------------
//   i_in    | in  | valid / ready | value[63:0], radix[5:0]
//   o_out   | out | valid / ready | digit_char[6:0], last (on final digit)
//
// Flow: the divider resolves four quotient bits per cycle and divides the value
// by the radix again and again, storing each remainder as a digit, until the
// quotient is zero; each digit is then read back from the digit store and
// loaded into the output register, most significant digit first.
// Reset: synchronous, active low; clears the queue, the sequencer and the
// output valid. No clearing pass is needed.
// Stalls: the two-entry queue takes input until full as the back end divides
// or waits on a stalled output; a held output freezes only the emit step.
// ----------------------------------------------------------------------------
module unsigned_to_radix_digits_top #(
    parameter int VALUE_BITS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    utrd_in_if.sink           i_in,
    utrd_out_if.source        o_out
);

    // Front to back: one queued job, already clamped and masked.
    logic                          job_valid;
    logic                          job_ready;
    logic [VALUE_BITS-1:0]         job_value;
    logic [utrd_pkg::RADIX_W-1:0]  job_radix;

    // Front: clamp the radix, mask the value and queue each transaction.
    utrd_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in.valid),
        .o_ready     (i_in.ready),
        .i_value     (i_in.value),
        .i_radix     (i_in.radix),
        .o_job_valid (job_valid),
        .i_job_ready (job_ready),
        .o_job_value (job_value),
        .o_job_radix (job_radix)
    );

    // Back: divide repeatedly, store digits, emit them in reverse.
    utrd_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .o_job_ready (job_ready),
        .i_job_value (job_value),
        .i_job_radix (job_radix),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_out_char  (o_out.digit_char),
        .o_out_last  (o_out.last)
    );

endmodule

@@ src/utrd_front.sv @@
// ----------------------------------------------------------------------------
// utrd_front
// Clamp the radix, mask the value and hold jobs in a two-entry queue.
// ----------------------------------------------------------------------------
module utrd_front #(
    parameter int VALUE_BITS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [utrd_pkg::VALUE_W-1:0]  i_value,
    input  logic [utrd_pkg::RADIX_W-1:0]  i_radix,
    output logic                          o_job_valid,
    input  logic                          i_job_ready,
    output logic [VALUE_BITS-1:0]         o_job_value,
    output logic [utrd_pkg::RADIX_W-1:0]  o_job_radix
);

    localparam int PTR_W = $clog2(utrd_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(utrd_pkg::QUEUE_DEPTH + 1);

    logic [VALUE_BITS-1:0]         r_val [utrd_pkg::QUEUE_DEPTH];
    logic [utrd_pkg::RADIX_W-1:0]  r_rad [utrd_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]              r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]              r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]              r_count,  n_count;
    logic                          push, pop;

    assign o_ready     = (r_count != CNT_W'(utrd_pkg::QUEUE_DEPTH));
    assign o_job_valid = (r_count != '0);
    assign o_job_value = r_val[r_rd_ptr];
    assign o_job_radix = r_rad[r_rd_ptr];

    assign push = i_valid && o_ready;
    assign pop  = o_job_valid && i_job_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = PTR_W'((32'(r_wr_ptr) + 1) % utrd_pkg::QUEUE_DEPTH);
        end
        if (pop) begin
            n_rd_ptr = PTR_W'((32'(r_rd_ptr) + 1) % utrd_pkg::QUEUE_DEPTH);
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Payload: bits above the value width are dropped here.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_val[r_wr_ptr] <= i_value[VALUE_BITS-1:0];
            r_rad[r_wr_ptr] <= utrd_pkg::clamp_radix(i_radix);
        end
    end

endmodule

@@ src/utrd_back.sv @@
// ----------------------------------------------------------------------------
// utrd_back
// Repeated division by the radix, digit store, and reverse-order emission.
// ----------------------------------------------------------------------------
module utrd_back #(
    parameter int VALUE_BITS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_job_valid,
    output logic                          o_job_ready,
    input  logic [VALUE_BITS-1:0]         i_job_value,
    input  logic [utrd_pkg::RADIX_W-1:0]  i_job_radix,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [utrd_pkg::CHAR_W-1:0]   o_out_char,
    output logic                          o_out_last
);

    localparam int BPS    = utrd_pkg::BITS_PER_STEP;
    localparam int STEPS  = (VALUE_BITS + BPS - 1) / BPS;
    localparam int WORK_W = STEPS * BPS;
    localparam int STEP_W = $clog2(STEPS);
    localparam int IDX_W  = $clog2(VALUE_BITS);
    localparam int RW     = utrd_pkg::RADIX_W;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_READ = 4'b0100,
        S_LOAD = 4'b1000
    } t_state;

    t_state                     r_state, n_state;
    logic [WORK_W-1:0]          r_q,     n_q;
    logic [RW-1:0]              r_rem,   n_rem;
    logic [RW-1:0]              r_rad,   n_rad;
    logic [STEP_W-1:0]          r_step,  n_step;
    logic [IDX_W-1:0]           r_cnt,   n_cnt;
    logic [IDX_W-1:0]           r_idx,   n_idx;
    logic                       r_out_valid, n_out_valid;
    logic [utrd_pkg::CHAR_W-1:0] r_out_char, n_out_char;
    logic                       r_out_last,  n_out_last;
    logic [RW-1:0]              r_rd_data;
    logic [RW-1:0]              r_digits [VALUE_BITS];

    logic [WORK_W-1:0]          div_q;
    logic [RW-1:0]              div_rem;
    logic [RW:0]                div_trial;
    logic                       digit_done;
    logic                       out_free;

    assign o_job_ready = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_out_last  = r_out_last;
    assign out_free    = !r_out_valid || i_out_ready;
    assign digit_done  = (r_state == S_DIV) && (r_step == STEP_W'(STEPS - 1));

    // Resolve BPS quotient bits, shifting them in at the bottom of r_q.
    always_comb begin
        div_rem   = r_rem;
        div_q     = r_q;
        div_trial = '0;
        for (int i = 0; i < BPS; i++) begin
            div_trial = {div_rem, div_q[WORK_W-1]};
            div_q     = {div_q[WORK_W-2:0], 1'b0};
            if (div_trial >= {1'b0, r_rad}) begin
                div_rem  = RW'(div_trial - {1'b0, r_rad});
                div_q[0] = 1'b1;
            end else begin
                div_rem = div_trial[RW-1:0];
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_q         = r_q;
        n_rem       = r_rem;
        n_rad       = r_rad;
        n_step      = r_step;
        n_cnt       = r_cnt;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        unique case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    n_q     = WORK_W'(i_job_value);
                    n_rad   = i_job_radix;
                    n_rem   = '0;
                    n_step  = '0;
                    n_cnt   = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_q    = div_q;
                n_rem  = div_rem;
                n_step = r_step + 1'b1;
                if (digit_done) begin
                    n_rem  = '0;
                    n_step = '0;
                    if (div_q == '0) begin
                        n_idx   = r_cnt;
                        n_state = S_READ;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            S_READ: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = utrd_pkg::digit_to_char(r_rd_data);
                    n_out_last  = (r_idx == '0);
                    if (r_idx == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx - 1'b1;
                        n_state = S_READ;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q        <= n_q;
        r_rem      <= n_rem;
        r_rad      <= n_rad;
        r_step     <= n_step;
        r_cnt      <= n_cnt;
        r_idx      <= n_idx;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

    // Digit store: least significant digit at index zero.
    always_ff @(posedge i_clk) begin
        if (digit_done) begin
            r_digits[r_cnt] <= div_rem;
        end
        if (r_state == S_READ) begin
            r_rd_data <= r_digits[r_idx];
        end
    end

endmodule

@@ src/utrd_checker.sv @@
// ----------------------------------------------------------------------------
// utrd_checker
// Port-level checks on the converter, bound to the top level.
// ----------------------------------------------------------------------------
module utrd_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [utrd_pkg::CHAR_W-1:0]   i_out_char,
    input  logic                          i_out_last
);

    logic [2:0] r_pending, n_pending;
    logic       in_take, last_take;

    assign in_take   = i_in_valid && i_in_ready;
    assign last_take = i_out_valid && i_out_ready && i_out_last;

    always_comb begin
        n_pending = r_pending;
        if (in_take && !last_take) begin
            n_pending = r_pending + 1'b1;
        end else if (last_take && !in_take) begin
            n_pending = r_pending - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= n_pending;
        end
    end

    // Hold a stalled digit unchanged.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_char) && $stable(i_out_last)))
        else $error("stalled digit changed");

    a_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((i_out_char >= 7'd48 && i_out_char <= 7'd57) ||
                         (i_out_char >= 7'd65 && i_out_char <= 7'd90)))
        else $error("digit character out of range");

    // No digit without an accepted, unfinished transaction.
    a_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (r_pending != 3'd0))
        else $error("digit with no pending transaction");

    a_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("output valid right after reset");

endmodule

bind unsigned_to_radix_digits_top utrd_checker u_utrd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_char  (o_out.digit_char),
    .i_out_last  (o_out.last)
);
